@@ rtl/typed_integer_binary_alu_macros.svh @@
// assertion macros for the typed integer binary alu
// used by the top level only, expects clk and rst in scope
`ifndef TYPED_INTEGER_BINARY_ALU_MACROS_SVH
`define TYPED_INTEGER_BINARY_ALU_MACROS_SVH

// same cycle implication
`define TIBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tiba check failed");

// next cycle implication
`define TIBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tiba check failed");

`endif

@@ rtl/tiba_pkg.sv @@
// shared codes, widths and the item tag for the typed integer alu
// no dependencies
package tiba_pkg;

  localparam int DATA_MAX       = 64;
  localparam int DATA_WIDTH_DEF = 64;

  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_SUB   = 5'd1;
  localparam logic [4:0] OP_MUL   = 5'd2;
  localparam logic [4:0] OP_DIV   = 5'd3;
  localparam logic [4:0] OP_MOD   = 5'd4;
  localparam logic [4:0] OP_FLOOR = 5'd5;
  localparam logic [4:0] OP_AND   = 5'd6;
  localparam logic [4:0] OP_OR    = 5'd7;
  localparam logic [4:0] OP_XOR   = 5'd8;
  localparam logic [4:0] OP_SHL   = 5'd9;
  localparam logic [4:0] OP_SHR   = 5'd10;
  localparam logic [4:0] OP_LT    = 5'd11;
  localparam logic [4:0] OP_LE    = 5'd12;
  localparam logic [4:0] OP_GT    = 5'd13;
  localparam logic [4:0] OP_GE    = 5'd14;
  localparam logic [4:0] OP_EQ    = 5'd15;
  localparam logic [4:0] OP_NE    = 5'd16;

  localparam logic [1:0] K_SIGNED   = 2'd0;
  localparam logic [1:0] K_UNSIGNED = 2'd1;
  localparam logic [1:0] K_BOOL     = 2'd2;
  localparam logic [1:0] K_NIL      = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_MIX     = 2'd3;

  typedef struct packed {
    logic [4:0]          func;
    logic [1:0]          kind;
    logic [1:0]          status;
    logic                sgn;
    logic                nega;
    logic                negb;
    logic [DATA_MAX-1:0] res;
  } tag_t;

endpackage

@@ rtl/tiba_div.sv @@
// pipelined restoring divider, one quotient bit per stage, tag carried along
// depends on tiba_pkg
module tiba_div #(
  parameter int DATA_WIDTH = tiba_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_v,
  input  tiba_pkg::tag_t        in_tag,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  out_v,
  output tiba_pkg::tag_t        out_tag,
  output logic [DATA_WIDTH-1:0] quot,
  output logic [DATA_WIDTH-1:0] rem
);
  import tiba_pkg::*;

  localparam int W = DATA_WIDTH;

  logic         v   [0:W];
  tag_t         tg  [0:W];
  logic [W-1:0] r   [0:W];
  logic [W-1:0] q   [0:W];
  logic [W-1:0] d   [0:W];

  assign v[0]  = in_v;
  assign tg[0] = in_tag;
  assign r[0]  = '0;
  assign q[0]  = dividend;
  assign d[0]  = divisor;

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [W:0]   rs;
    logic         ge;
    logic [W:0]   diff;
    logic [W-1:0] r_next;
    logic [W-1:0] q_next;

    always_comb begin
      rs     = {r[k], q[k][W-1]};
      diff   = rs - {1'b0, d[k]};
      ge     = rs >= {1'b0, d[k]};
      r_next = ge ? diff[W-1:0] : rs[W-1:0];
      q_next = {q[k][W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tg[k+1] <= tg[k];
        r[k+1]  <= r_next;
        q[k+1]  <= q_next;
        d[k+1]  <= d[k];
      end
    end
  end

  assign out_v   = v[W];
  assign out_tag = tg[W];
  assign quot    = q[W];
  assign rem     = r[W];

endmodule

@@ rtl/typed_integer_binary_alu.sv @@
// typed integer alu: pipelined, one item per cycle unless the output stalls
// pipe stages are decode, product, DATA_WIDTH divider stages and fix-up
// the whole pipe advances together when the output register is empty or taken
// synchronous reset clears all valid bits; payload registers are not reset
// depends on tiba_pkg, tiba_div and typed_integer_binary_alu_macros.svh
module typed_integer_binary_alu #(
  parameter int DATA_WIDTH = tiba_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // func, left_kind, left_value, right_kind, right_value, zero pad
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_kind, result_value, status, zero pad
  output logic [71:0]  m_tdata
);
  import tiba_pkg::*;
  `include "typed_integer_binary_alu_macros.svh"

  localparam int W = DATA_WIDTH;
  localparam int H = (W + 1) / 2;
  localparam int L = W - H;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // input decode
  logic [4:0]   func;
  logic [1:0]   lk, rk;
  logic [W-1:0] a, b, ca, cb, simple, ma, mb;
  logic [5:0]   amt;
  logic         sgn, lt, eq;
  tag_t         tag_in;

  always_comb begin
    func   = s_tdata[4:0];
    lk     = s_tdata[6:5];
    a      = s_tdata[7 +: W];
    rk     = s_tdata[72:71];
    b      = s_tdata[73 +: W];
    sgn    = lk == K_SIGNED;
    amt    = b[5:0];
    ca     = a ^ {sgn, {(W-1){1'b0}}};
    cb     = b ^ {sgn, {(W-1){1'b0}}};
    lt     = ca < cb;
    eq     = ca == cb;
    ma     = (sgn && a[W-1]) ? -a : a;
    mb     = (sgn && b[W-1]) ? -b : b;
    case (func)
      OP_ADD:  simple = a + b;
      OP_SUB:  simple = a - b;
      OP_AND:  simple = a & b;
      OP_OR:   simple = a | b;
      OP_XOR:  simple = a ^ b;
      OP_SHL:  simple = a << amt;
      OP_SHR:  simple = sgn ? W'($signed(a) >>> amt) : a >> amt;
      OP_LT:   simple = W'(lt);
      OP_LE:   simple = W'(lt || eq);
      OP_GT:   simple = W'(!(lt || eq));
      OP_GE:   simple = W'(!lt);
      OP_EQ:   simple = W'(eq);
      OP_NE:   simple = W'(!eq);
      default: simple = '0;
    endcase
    tag_in.func   = func;
    tag_in.sgn    = sgn;
    tag_in.nega   = sgn && a[W-1];
    tag_in.negb   = sgn && b[W-1];
    tag_in.kind   = lk;
    tag_in.status = ST_OK;
    tag_in.res    = DATA_MAX'(simple);
    if (lk == K_NIL || rk == K_NIL || func > OP_NE) begin
      tag_in.kind   = K_NIL;
      tag_in.status = ST_INVALID;
      tag_in.res    = '0;
    end else if (lk == K_BOOL || rk == K_BOOL) begin
      if (lk == K_BOOL && rk == K_BOOL && (func == OP_EQ || func == OP_NE)) begin
        tag_in.res = DATA_MAX'((a[0] == b[0]) == (func == OP_EQ));
      end else begin
        tag_in.kind   = K_NIL;
        tag_in.status = ST_INVALID;
        tag_in.res    = '0;
      end
    end else if (lk != rk) begin
      tag_in.kind   = K_NIL;
      tag_in.status = ST_MIX;
      tag_in.res    = '0;
    end else if ((func == OP_DIV || func == OP_MOD || func == OP_FLOOR) && b == '0) begin
      tag_in.kind   = K_NIL;
      tag_in.status = ST_DIVZERO;
      tag_in.res    = '0;
    end else if (func >= OP_LT) begin
      tag_in.kind = K_BOOL;
    end
  end

  // stage a: decode and partial products
  logic         a_v;
  tag_t         a_tag;
  logic [W-1:0] a_ma, a_mb;
  logic [2*H-1:0] a_pll;
  logic [L-1:0] a_plh, a_phl;
  logic [2*H-1:0] pll;
  logic [L-1:0] plh, phl;

  always_comb begin
    pll = a[H-1:0] * b[H-1:0];
    plh = a[L-1:0] * b[W-1:H];
    phl = a[W-1:H] * b[L-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag <= tag_in;
      a_ma  <= ma;
      a_mb  <= mb;
      a_pll <= pll;
      a_plh <= plh;
      a_phl <= phl;
    end
  end

  // stage b: product sum
  logic         b_v;
  tag_t         b_tag;
  logic [W-1:0] b_ma, b_mb, prod;
  logic [L-1:0] xsum;

  always_comb begin
    xsum = a_plh + a_phl;
    prod = a_pll[W-1:0] + {xsum, {H{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_tag <= a_tag;
      if (a_tag.func == OP_MUL && a_tag.status == ST_OK) begin
        b_tag.res <= DATA_MAX'(prod);
      end
      b_ma <= a_ma;
      b_mb <= a_mb;
    end
  end

  // division
  logic         d_v;
  tag_t         d_tag;
  logic [W-1:0] d_q, d_r;

  tiba_div #(
    .DATA_WIDTH(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_v     (b_v),
    .in_tag   (b_tag),
    .dividend (b_ma),
    .divisor  (b_mb),
    .out_v    (d_v),
    .out_tag  (d_tag),
    .quot     (d_q),
    .rem      (d_r)
  );

  // sign fix-up and output register
  logic [W-1:0]  dres;
  logic [63:0]   value;
  logic          diff;

  always_comb begin
    diff = d_tag.nega ^ d_tag.negb;
    if (d_tag.func == OP_MOD) begin
      dres = d_tag.nega ? -d_r : d_r;
    end else if (d_tag.func == OP_FLOOR && diff && d_r != '0) begin
      dres = ~d_q;
    end else begin
      dres = diff ? -d_q : d_q;
    end
    value = d_tag.res;
    if ((d_tag.func == OP_DIV || d_tag.func == OP_MOD || d_tag.func == OP_FLOOR)
        && d_tag.status == ST_OK) begin
      value = 64'(dres);
    end
    if (d_tag.kind == K_NIL) begin
      value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'd0, d_tag.status, value, d_tag.kind};
    end
  end

  `TIBA_ASSERT_NOW(a_nil_zero, m_tvalid && m_tdata[1:0] == K_NIL, m_tdata[65:2] == 64'd0)
  `TIBA_ASSERT_NOW(a_err_nil, m_tvalid && m_tdata[67:66] != ST_OK, m_tdata[1:0] == K_NIL)
  `TIBA_ASSERT_NOW(a_bool_bit, m_tvalid && m_tdata[1:0] == K_BOOL, m_tdata[65:3] == 63'd0)
  `TIBA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

@@ bench/typed_integer_binary_alu_tb.sv @@
// testbench for the typed integer alu: directed corner items then random traffic
// predicts each result in a local model and compares field by field; needs tiba_pkg
`timescale 1ns / 100ps

module typed_integer_binary_alu_tb;
  import tiba_pkg::*;

  localparam int W = 64;
  localparam int LATENCY = W + 3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [63:0] rval;
    logic [1:0]  rkind;
    logic [63:0] lval;
    logic [1:0]  lkind;
    logic [4:0]  func;
  } op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
    logic [1:0]  kind;
  } res_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [143:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [71:0] m_tdata;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   errors = 0;
  int   cycles = 0;
  int   src_idle = 0;
  int   sink_idle = 0;
  int   hold_off = 0;
  bit   quiet = 0;
  bit   src_pause = 0;
  int   n_checked = 0;

  typed_integer_binary_alu #(.DATA_WIDTH(W)) dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic res_t alu_predict(op_t o);
    res_t r;
    logic [63:0] a, b, ma, mb, q, rm, sb;
    logic na, nb;
    r = '{status: ST_OK, value: '0, kind: K_NIL};
    a = o.lval;
    b = o.rval;
    sb = 64'h1 << 63;
    if (o.lkind == K_NIL || o.rkind == K_NIL || o.func > OP_NE) begin
      r.status = ST_INVALID;
      return r;
    end
    if (o.lkind == K_BOOL || o.rkind == K_BOOL) begin
      if (o.lkind == K_BOOL && o.rkind == K_BOOL && (o.func == OP_EQ || o.func == OP_NE)) begin
        r.kind = K_BOOL;
        r.value = 64'((a[0] == b[0]) ^ (o.func == OP_NE));
      end else begin
        r.status = ST_INVALID;
      end
      return r;
    end
    if (o.lkind != o.rkind) begin
      r.status = ST_MIX;
      return r;
    end
    if (o.func inside {OP_DIV, OP_MOD, OP_FLOOR} && b == 0) begin
      r.status = ST_DIVZERO;
      return r;
    end
    if (o.lkind == K_SIGNED) begin
      na = a[63];
      nb = b[63];
    end else begin
      na = 0;
      nb = 0;
    end
    if (o.func >= OP_LT) begin
      if (o.lkind == K_SIGNED) begin
        a ^= sb;
        b ^= sb;
      end
      r.kind = K_BOOL;
      case (o.func)
        OP_LT: r.value = 64'(a < b);
        OP_LE: r.value = 64'(a <= b);
        OP_GT: r.value = 64'(a > b);
        OP_GE: r.value = 64'(a >= b);
        OP_EQ: r.value = 64'(a == b);
        default: r.value = 64'(a != b);
      endcase
      return r;
    end
    r.kind = o.lkind;
    ma = na ? -a : a;
    mb = nb ? -b : b;
    q = ma / mb;
    rm = ma % mb;
    case (o.func)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: r.value = a * b;
      OP_DIV: r.value = (na != nb) ? -q : q;
      OP_MOD: r.value = na ? -rm : rm;
      OP_FLOOR: r.value = (na != nb) ? -q - 64'(rm != 0) : q;
      OP_AND: r.value = a & b;
      OP_OR:  r.value = a | b;
      OP_XOR: r.value = a ^ b;
      OP_SHL: r.value = a << b[5:0];
      default: r.value = na ? ~((~a) >> b[5:0]) : a >> b[5:0];
    endcase
    return r;
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return 64'h1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7fff_ffff_ffff_ffff;
      5: return 64'($urandom_range(0, 20));
      6: return -64'($urandom_range(1, 20));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_op(logic [4:0] f, logic [1:0] lk, logic [63:0] lv,
                         logic [1:0] rk, logic [63:0] rv);
    op_t o;
    o.func = f;
    o.lkind = lk;
    o.lval = lv;
    o.rkind = rk;
    o.rval = rv;
    pending_ops.push_back(o);
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(alu_predict(op_t'(s_tdata[136:0])));
      end
      if (!s_tvalid || s_tready) begin
        if (src_idle > 0) begin
          src_idle <= src_idle - 1;
          s_tvalid <= 0;
        end else if (pending_ops.size() > 0 && !src_pause) begin
          s_tdata <= {7'b0, pending_ops.pop_front()};
          s_tvalid <= 1;
          if (!quiet && $urandom_range(0, 5) == 0) src_idle <= $urandom_range(1, 4);
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got, exp_r;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[67:0];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          n_checked++;
          if (got.kind !== exp_r.kind)
            $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
          if (got.value !== exp_r.value)
            $display("%0t: value expected %h actual %h", $time, exp_r.value, got.value);
          if (got.status !== exp_r.status)
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
          if (got !== exp_r) errors++;
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 0;
      end else if (sink_idle > 0) begin
        sink_idle <= sink_idle - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        if (!quiet && $urandom_range(0, 5) == 0) sink_idle <= $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [1:0] k;
    repeat (6) @(posedge clk);
    rst <= 0;
    // directed corners
    for (int f = 0; f <= 16; f++)
      push_op(5'(f), K_SIGNED, 64'h8000_0000_0000_0000, K_SIGNED, '1);
    push_op(OP_DIV, K_UNSIGNED, 64'd7, K_UNSIGNED, 64'd0);
    push_op(OP_FLOOR, K_SIGNED, -64'd7, K_SIGNED, 64'd2);
    push_op(OP_MOD, K_SIGNED, -64'd7, K_SIGNED, 64'd2);
    push_op(OP_SHR, K_SIGNED, -64'd8, K_SIGNED, 64'hffc0);
    push_op(OP_EQ, K_BOOL, 64'd1, K_BOOL, 64'd3);
    push_op(OP_ADD, K_BOOL, 64'd1, K_SIGNED, 64'd3);
    push_op(OP_ADD, K_SIGNED, 64'd1, K_UNSIGNED, 64'd3);
    push_op(5'd31, K_NIL, '1, K_SIGNED, '1);
    // random, mostly same-kind pairs
    for (int i = 0; i < 880; i++) begin
      k = $urandom_range(0, 9) < 7 ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 3));
      push_op($urandom_range(0, 9) == 0 ? 5'($urandom) : 5'($urandom_range(0, 16)), k,
              pick_value(), $urandom_range(0, 9) < 8 ? k : 2'($urandom_range(0, 3)),
              pick_value());
      if (i == 300) begin
        hold_off <= 200;
      end
      if (i == 500) begin
        // let the pipe drain fully before resuming
        wait (pending_ops.size() == 0);
        src_pause = 1;
        wait (!s_tvalid && expected_results.size() == 0);
        @(posedge clk);
        src_pause = 0;
      end
      if (i == 700) quiet = 1;
    end
    wait (pending_ops.size() == 0 && !s_tvalid && expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("checked %0d results over all opcodes, kinds and division corners", n_checked);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
